[src/assert_macros.svh]
// assertion macros for the rtl, included by the flattener top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CBF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CBF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CBF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CBF_ASSERT(lbl, prop, msg)
`define CBF_ASSERT_IMPL(lbl, ante, cons, msg)
`define CBF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[src/cbf_pkg.sv]
// types, constants and state codes of the bezier flattener
package cbf_pkg;
    localparam int MAX_DEPTH   = 5;
    localparam int COORD_BITS  = 24;
    localparam int TOL_BITS    = 48;
    localparam int CNT_BITS    = 6;
    localparam int MAX_SAMPLES = 32;
    localparam int CNT_RESET   = 10;
    localparam int DEN_BITS    = 16;
    localparam int WT_W        = 16;
    localparam int ACC_BITS    = COORD_BITS + DEN_BITS;
    localparam int SM_A_W      = 2 * CNT_BITS;
    localparam int SM_P_W      = SM_A_W + CNT_BITS;
    localparam int SM3_W       = SM_P_W + 1;
    localparam int DIFF_W      = COORD_BITS + 3;
    localparam int ABS_W       = COORD_BITS + 2;
    localparam int SQ_W        = 2 * ABS_W;
    localparam int FLAT_W      = SQ_W + 1;
    localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
    localparam int LVL_IW      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int STK_DEPTH   = 4 * MAX_DEPTH;
    localparam int STK_AW      = $clog2(STK_DEPTH);
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 64;

    localparam logic REG_TOL = 1'b0;
    localparam logic REG_CNT = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] ctrl1_x;
        logic signed [COORD_BITS-1:0] ctrl1_y;
        logic signed [COORD_BITS-1:0] ctrl2_x;
        logic signed [COORD_BITS-1:0] ctrl2_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic                         first_segment;
        logic                         last_segment;
    } cbf_seg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         last_of_segment;
        logic                         end_of_path;
    } cbf_pt_t;

    typedef struct packed {
        logic                start;
        logic [ACC_BITS-1:0] dividend;
        logic [DEN_BITS-1:0] divisor;
    } cbf_div_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_DEN0,
        ST_DEN1,
        ST_FX_SQA,
        ST_FX_SQJ,
        ST_FX_WT,
        ST_FX_MAC,
        ST_FX_DSTART,
        ST_FX_DWAIT,
        ST_FX_EMIT,
        ST_AD_TEST,
        ST_AD_FLAT,
        ST_AD_CMP,
        ST_AD_HALVE,
        ST_AD_PUSH,
        ST_AD_EMIT,
        ST_AD_POP
    } cbf_state_t;
endpackage

[src/cbf_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
module cbf_div
    import cbf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cbf_div_req_t          req,
    output logic                  done,
    output logic [COORD_BITS-1:0] quot
);
    localparam int STEP_W = $clog2(COORD_BITS + 1);

    logic [DEN_BITS-1:0]   rem_reg;
    logic [DEN_BITS-1:0]   den_reg;
    logic [COORD_BITS-1:0] q_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DEN_BITS:0]     trial;
    logic                  fits;

    assign trial = {rem_reg, q_reg[COORD_BITS-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign done  = done_reg;
    assign quot  = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(COORD_BITS);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // upper dividend bits are below the divisor, so only the quotient bits iterate
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend[ACC_BITS-1 -: DEN_BITS];
            q_reg   <= req.dividend[COORD_BITS-1:0];
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_BITS'(trial - {1'b0, den_reg}) : trial[DEN_BITS-1:0];
            q_reg   <= {q_reg[COORD_BITS-2:0], fits};
        end
    end
endmodule

[src/cubic_bezier_flattener.sv]
// cubic bezier flattener top level: sequencer, shared arithmetic and subdivision stack
//
// seg channel (valid/ready): one transfer carries one cubic segment, four signed
// Q16.8 control points plus first/last flags. pt channel (valid/ready): one transfer
// per polyline point; last_of_segment marks the final point of a segment and
// end_of_path that point of a segment flagged last_segment.
// apb port: flat_tolerance at 0x0 (48 bits), sample_count at 0x8, write when idle.
// tolerance zero: N = sample_count points (0 read as 1, capped at 32), evaluated with
// one small multiplier for the Bernstein weights, a 16x24 multiply-accumulate and one
// divider, which is used once per axis of each point.
// tolerance nonzero: halving with a squarer flatness test, the right halves go into
// the stack memory and are popped back from it; up to 32 points.
// an optional start point leaves from the start state. seg_ready is high only between
// segments. results leave through one output register: when the receiver stalls, the
// sequencer holds at the next point until the register frees up.
// reset clears the sequencer and output valid; tolerance returns to 0 and
// sample_count to 10. the stack needs no clearing, it is always written first.
module cubic_bezier_flattener
    import cbf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               seg_valid,
    output logic               seg_ready,
    input  cbf_seg_t           seg,
    output logic               pt_valid,
    input  logic               pt_ready,
    output cbf_pt_t            pt
);
    `include "assert_macros.svh"

    cbf_state_t state_reg, state_next;

    logic [TOL_BITS-1:0]   tol_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  cfg_we;
    logic                  reg_idx;
    logic [CNT_BITS-1:0]   n_eff;

    logic [COORD_BITS-1:0] cur_x [4];
    logic [COORD_BITS-1:0] cur_y [4];
    logic [COORD_BITS-1:0] rt_x [4];
    logic [COORD_BITS-1:0] rt_y [4];
    logic                  first_reg;
    logic                  last_reg;

    logic [CNT_BITS-1:0]   n_reg;
    logic [CNT_BITS-1:0]   j_reg;
    logic [CNT_BITS-1:0]   a_val;
    logic                  axis_reg;
    logic [1:0]            k_reg;
    logic [SM_A_W-1:0]     sqa_reg;
    logic [SM_A_W-1:0]     sqj_reg;
    logic [WT_W-1:0]       w_reg;
    logic [DEN_BITS-1:0]   den_reg;
    logic [ACC_BITS-1:0]   acc_reg;
    logic [COORD_BITS-1:0] qx_reg;
    logic [SM_A_W-1:0]     sm_a;
    logic [CNT_BITS-1:0]   sm_b;
    logic [SM_P_W-1:0]     sm_p;
    logic [SM3_W-1:0]      sm_x3;
    logic [COORD_BITS-1:0] mac_coord;
    logic [ACC_BITS-1:0]   mac_p;

    cbf_div_req_t          div_req;
    logic                  div_done;
    logic [COORD_BITS-1:0] div_quot;

    logic [DEPTH_W-1:0]    lvl_reg;
    logic [DEPTH_W-1:0]    d_reg;
    logic [DEPTH_W-1:0]    depth_arr [MAX_DEPTH];
    logic [2:0]            fk_reg;
    logic [2:0]            pk_reg;
    logic [1:0]            pk_m1;
    logic [COORD_BITS-1:0] fl_a, fl_b, fl_c;
    logic [DIFF_W-1:0]     fl_d;
    logic [ABS_W-1:0]      fl_abs;
    logic [SQ_W-1:0]       fl_sq;
    logic [SQ_W-1:0]       sq_reg, mx_reg, my_reg;
    logic [FLAT_W-1:0]     flat_sum;
    logic                  flat_ok;

    logic [COORD_BITS-1:0] hx_a, hx_b, hx_c, hx_ab, hx_bc, hx_m;
    logic [COORD_BITS-1:0] hy_a, hy_b, hy_c, hy_ab, hy_bc, hy_m;

    logic [2*COORD_BITS-1:0] stk_mem [STK_DEPTH];
    logic [2*COORD_BITS-1:0] stk_rd_reg;
    logic [STK_AW-1:0]       stk_addr;
    logic                    stk_we;

    cbf_pt_t               pt_reg;
    logic                  pt_valid_reg;
    logic                  out_free;
    logic                  emit_fire;
    logic                  emit_last;
    logic [COORD_BITS-1:0] emit_x, emit_y;
    logic                  start_done;

    function automatic logic [COORD_BITS-1:0] flip(input logic [COORD_BITS-1:0] v);
        return {~v[COORD_BITS-1], v[COORD_BITS-2:0]};
    endfunction

    function automatic logic [COORD_BITS-1:0] mid(input logic [COORD_BITS-1:0] a,
                                                  input logic [COORD_BITS-1:0] b);
        logic [COORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COORD_BITS:1];
    endfunction

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite;
    assign reg_idx = paddr[PADDR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
            cnt_reg <= CNT_BITS'(CNT_RESET);
        end
        else if (cfg_we)
        begin
            unique case (reg_idx)
                REG_TOL: tol_reg <= pwdata[TOL_BITS-1:0];
                REG_CNT: cnt_reg <= pwdata[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TOL: prdata = PDATA_W'(tol_reg);
            REG_CNT: prdata = PDATA_W'(cnt_reg);
            default: prdata = '0;
        endcase
    end

    always_comb
    begin
        if (cnt_reg == '0)
            n_eff = CNT_BITS'(1);
        else if (cnt_reg > CNT_BITS'(MAX_SAMPLES))
            n_eff = CNT_BITS'(MAX_SAMPLES);
        else
            n_eff = cnt_reg;
    end

    // small multiplier for cubes and Bernstein weights
    assign a_val = n_reg - j_reg;

    always_comb
    begin
        sm_a = '0;
        sm_b = '0;
        unique case (state_reg)
            ST_DEN0:
            begin
                sm_a = SM_A_W'(n_reg);
                sm_b = n_reg;
            end
            ST_DEN1:
            begin
                sm_a = sqa_reg;
                sm_b = n_reg;
            end
            ST_FX_SQA:
            begin
                sm_a = SM_A_W'(a_val);
                sm_b = a_val;
            end
            ST_FX_SQJ:
            begin
                sm_a = SM_A_W'(j_reg);
                sm_b = j_reg;
            end
            ST_FX_WT:
            begin
                sm_a = k_reg[1] ? sqj_reg : sqa_reg;
                sm_b = (k_reg == 2'd0 || k_reg == 2'd2) ? a_val : j_reg;
            end
            default: ;
        endcase
    end

    assign sm_p      = SM_P_W'(sm_a) * SM_P_W'(sm_b);
    assign sm_x3     = SM3_W'(sm_p) + (SM3_W'(sm_p) << 1);
    assign mac_coord = axis_reg ? cur_y[k_reg] : cur_x[k_reg];
    assign mac_p     = w_reg * mac_coord;

    assign div_req.start    = (state_reg == ST_FX_DSTART);
    assign div_req.dividend = acc_reg + ACC_BITS'(den_reg >> 1);
    assign div_req.divisor  = den_reg;

    cbf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    // flatness: one squared axis difference per cycle
    always_comb
    begin
        case (fk_reg[1:0])
            2'd0:
            begin
                fl_a = cur_x[1]; fl_b = cur_x[0]; fl_c = cur_x[3];
            end
            2'd1:
            begin
                fl_a = cur_x[2]; fl_b = cur_x[3]; fl_c = cur_x[0];
            end
            2'd2:
            begin
                fl_a = cur_y[1]; fl_b = cur_y[0]; fl_c = cur_y[3];
            end
            default:
            begin
                fl_a = cur_y[2]; fl_b = cur_y[3]; fl_c = cur_y[0];
            end
        endcase
    end

    assign fl_d     = (DIFF_W'(fl_a) << 1) + DIFF_W'(fl_a) - (DIFF_W'(fl_b) << 1)
                      - DIFF_W'(fl_c);
    assign fl_abs   = fl_d[DIFF_W-1] ? ABS_W'(-fl_d) : ABS_W'(fl_d);
    assign fl_sq    = SQ_W'(fl_abs) * SQ_W'(fl_abs);
    assign flat_sum = FLAT_W'(mx_reg) + FLAT_W'(my_reg);
    assign flat_ok  = flat_sum <= FLAT_W'(tol_reg);

    // de casteljau halving of both axes
    assign hx_a  = mid(cur_x[0], cur_x[1]);
    assign hx_b  = mid(cur_x[1], cur_x[2]);
    assign hx_c  = mid(cur_x[2], cur_x[3]);
    assign hx_ab = mid(hx_a, hx_b);
    assign hx_bc = mid(hx_b, hx_c);
    assign hx_m  = mid(hx_ab, hx_bc);
    assign hy_a  = mid(cur_y[0], cur_y[1]);
    assign hy_b  = mid(cur_y[1], cur_y[2]);
    assign hy_c  = mid(cur_y[2], cur_y[3]);
    assign hy_ab = mid(hy_a, hy_b);
    assign hy_bc = mid(hy_b, hy_c);
    assign hy_m  = mid(hy_ab, hy_bc);

    assign stk_addr = STK_AW'({lvl_reg, pk_reg[1:0]});
    assign pk_m1    = 2'(pk_reg - 3'd1);

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_addr] <= {rt_y[pk_reg[1:0]], rt_x[pk_reg[1:0]]};
        stk_rd_reg <= stk_mem[stk_addr];
    end

    assign out_free   = !pt_valid_reg || pt_ready;
    assign start_done = !first_reg || out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (seg_valid) state_next = ST_START;
            ST_START:
                if (start_done)
                    state_next = (tol_reg != '0) ? ST_AD_TEST : ST_DEN0;
            ST_DEN0:      state_next = ST_DEN1;
            ST_DEN1:      state_next = ST_FX_SQA;
            ST_FX_SQA:    state_next = ST_FX_SQJ;
            ST_FX_SQJ:    state_next = ST_FX_WT;
            ST_FX_WT:     state_next = ST_FX_MAC;
            ST_FX_MAC:    state_next = (k_reg == 2'd3) ? ST_FX_DSTART : ST_FX_WT;
            ST_FX_DSTART: state_next = ST_FX_DWAIT;
            ST_FX_DWAIT:
                if (div_done)
                    state_next = axis_reg ? ST_FX_EMIT : ST_FX_WT;
            ST_FX_EMIT:
                if (out_free)
                    state_next = (j_reg == n_reg) ? ST_IDLE : ST_FX_SQA;
            ST_AD_TEST:
                state_next = (d_reg >= DEPTH_W'(MAX_DEPTH)) ? ST_AD_EMIT : ST_AD_FLAT;
            ST_AD_FLAT:   if (fk_reg == 3'd4) state_next = ST_AD_CMP;
            ST_AD_CMP:    state_next = flat_ok ? ST_AD_EMIT : ST_AD_HALVE;
            ST_AD_HALVE:  state_next = ST_AD_PUSH;
            ST_AD_PUSH:   if (pk_reg == 3'd3) state_next = ST_AD_TEST;
            ST_AD_EMIT:
                if (out_free)
                    state_next = (lvl_reg == '0) ? ST_IDLE : ST_AD_POP;
            ST_AD_POP:    if (pk_reg == 3'd4) state_next = ST_AD_TEST;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        seg_ready = 1'b0;
        stk_we    = 1'b0;
        emit_fire = 1'b0;
        emit_last = 1'b0;
        emit_x    = cur_x[3];
        emit_y    = cur_y[3];
        unique case (state_reg)
            ST_IDLE:    seg_ready = 1'b1;
            ST_START:
            begin
                emit_fire = first_reg & out_free;
                emit_x    = cur_x[0];
                emit_y    = cur_y[0];
            end
            ST_FX_EMIT:
            begin
                emit_fire = out_free;
                emit_last = (j_reg == n_reg);
                emit_x    = qx_reg;
                emit_y    = div_quot;
            end
            ST_AD_PUSH: stk_we = 1'b1;
            ST_AD_EMIT:
            begin
                emit_fire = out_free;
                emit_last = (lvl_reg == '0);
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lvl_reg   <= '0;
            d_reg     <= '0;
            j_reg     <= '0;
            fk_reg    <= '0;
            pk_reg    <= '0;
            k_reg     <= '0;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_START:
                    if (start_done)
                    begin
                        lvl_reg <= '0;
                        d_reg   <= '0;
                        j_reg   <= CNT_BITS'(1);
                    end
                ST_FX_SQJ:
                begin
                    k_reg    <= '0;
                    axis_reg <= 1'b0;
                end
                ST_FX_MAC:  k_reg <= k_reg + 2'd1;
                ST_FX_DWAIT:
                    if (div_done && !axis_reg)
                    begin
                        axis_reg <= 1'b1;
                        k_reg    <= '0;
                    end
                ST_FX_EMIT:
                    if (out_free && j_reg != n_reg)
                        j_reg <= j_reg + 1'b1;
                ST_AD_TEST: fk_reg <= '0;
                ST_AD_FLAT: fk_reg <= fk_reg + 3'd1;
                ST_AD_HALVE:
                begin
                    d_reg  <= d_reg + 1'b1;
                    pk_reg <= '0;
                end
                ST_AD_PUSH:
                begin
                    pk_reg <= pk_reg + 3'd1;
                    if (pk_reg == 3'd3)
                        lvl_reg <= lvl_reg + 1'b1;
                end
                ST_AD_EMIT:
                    if (out_free && lvl_reg != '0)
                    begin
                        lvl_reg <= lvl_reg - 1'b1;
                        pk_reg  <= '0;
                    end
                ST_AD_POP:
                begin
                    pk_reg <= pk_reg + 3'd1;
                    if (pk_reg == 3'd4)
                        d_reg <= depth_arr[lvl_reg[LVL_IW-1:0]];
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (seg_valid)
                begin
                    cur_x[0]  <= flip(seg.start_x);
                    cur_y[0]  <= flip(seg.start_y);
                    cur_x[1]  <= flip(seg.ctrl1_x);
                    cur_y[1]  <= flip(seg.ctrl1_y);
                    cur_x[2]  <= flip(seg.ctrl2_x);
                    cur_y[2]  <= flip(seg.ctrl2_y);
                    cur_x[3]  <= flip(seg.end_x);
                    cur_y[3]  <= flip(seg.end_y);
                    first_reg <= seg.first_segment;
                    last_reg  <= seg.last_segment;
                end
            ST_START:  n_reg   <= n_eff;
            ST_DEN0:   sqa_reg <= SM_A_W'(sm_p);
            ST_DEN1:   den_reg <= DEN_BITS'(sm_p);
            ST_FX_SQA: sqa_reg <= SM_A_W'(sm_p);
            ST_FX_SQJ:
            begin
                sqj_reg <= SM_A_W'(sm_p);
                acc_reg <= '0;
            end
            ST_FX_WT:
                w_reg <= (k_reg == 2'd1 || k_reg == 2'd2) ? WT_W'(sm_x3) : WT_W'(sm_p);
            ST_FX_MAC: acc_reg <= acc_reg + mac_p;
            ST_FX_DWAIT:
                if (div_done && !axis_reg)
                begin
                    qx_reg  <= div_quot;
                    acc_reg <= '0;
                end
            ST_AD_FLAT:
            begin
                if (fk_reg != 3'd4)
                    sq_reg <= fl_sq;
                case (fk_reg)
                    3'd1:    mx_reg <= sq_reg;
                    3'd2:    mx_reg <= (sq_reg > mx_reg) ? sq_reg : mx_reg;
                    3'd3:    my_reg <= sq_reg;
                    3'd4:    my_reg <= (sq_reg > my_reg) ? sq_reg : my_reg;
                    default: ;
                endcase
            end
            ST_AD_HALVE:
            begin
                cur_x[1] <= hx_a;
                cur_x[2] <= hx_ab;
                cur_x[3] <= hx_m;
                cur_y[1] <= hy_a;
                cur_y[2] <= hy_ab;
                cur_y[3] <= hy_m;
                rt_x[0]  <= hx_m;
                rt_x[1]  <= hx_bc;
                rt_x[2]  <= hx_c;
                rt_x[3]  <= cur_x[3];
                rt_y[0]  <= hy_m;
                rt_y[1]  <= hy_bc;
                rt_y[2]  <= hy_c;
                rt_y[3]  <= cur_y[3];
                depth_arr[lvl_reg[LVL_IW-1:0]] <= d_reg + 1'b1;
            end
            ST_AD_POP:
                if (pk_reg != 3'd0)
                begin
                    cur_x[pk_m1] <= stk_rd_reg[COORD_BITS-1:0];
                    cur_y[pk_m1] <= stk_rd_reg[2*COORD_BITS-1:COORD_BITS];
                end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pt_valid_reg <= 1'b0;
        else if (emit_fire)
            pt_valid_reg <= 1'b1;
        else if (pt_ready)
            pt_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            pt_reg.point_x         <= flip(emit_x);
            pt_reg.point_y         <= flip(emit_y);
            pt_reg.last_of_segment <= emit_last;
            pt_reg.end_of_path     <= emit_last & last_reg;
        end
    end

    assign pt_valid = pt_valid_reg;
    assign pt       = pt_reg;

    `CBF_ASSERT(a_eop_has_last, !(pt_valid && pt.end_of_path && !pt.last_of_segment), "end_of_path without last_of_segment")
    `CBF_ASSERT(a_level_bound, lvl_reg <= DEPTH_W'(MAX_DEPTH) && d_reg <= DEPTH_W'(MAX_DEPTH), "subdivision level out of range")
    `CBF_ASSERT_NEXT(a_last_ends_item, emit_fire && emit_last, state_reg == ST_IDLE, "segment continues after its last point")
    `CBF_ASSERT_IMPL(a_emit_needs_room, emit_fire, !pt_valid || pt_ready, "point written over a pending transfer")
endmodule

[test/tb_top.sv]
// testbench for the cubic bezier flattener: self-predicting checker with random stalls
module tb_top;
    import cbf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] OFS      = 64'h80_0000;
    localparam logic [63:0] TOL_MAX  = 64'hFFFF_FFFF_FFFF;
    localparam int          HOLD_LEN = 600;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               seg_valid;
    logic               seg_ready;
    cbf_seg_t           seg;
    logic               pt_valid;
    logic               pt_ready;
    cbf_pt_t            pt;

    cbf_pt_t     pending_pts[$];
    logic [63:0] tol_reg;
    logic [5:0]  cnt_reg;
    int          err_count;
    bit          idle_en;
    bit          hold_req;

    cubic_bezier_flattener dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic logic [63:0] to_ofs(logic [COORD_BITS-1:0] v);
        return {40'b0, v} ^ OFS;
    endfunction

    function automatic void add_point(logic [63:0] ux, logic [63:0] uy);
        cbf_pt_t p;
        p.point_x         = ux[COORD_BITS-1:0] ^ OFS[COORD_BITS-1:0];
        p.point_y         = uy[COORD_BITS-1:0] ^ OFS[COORD_BITS-1:0];
        p.last_of_segment = 1'b0;
        p.end_of_path     = 1'b0;
        pending_pts.insert(pending_pts.size(), p);
    endfunction

    function automatic logic [63:0] axis_dev(logic [63:0] a, logic [63:0] b, logic [63:0] c);
        longint d;
        longint unsigned m;
        d = 3 * longint'(a) - 2 * longint'(b) - longint'(c);
        m = (d < 0) ? -d : d;
        if (m >= 64'h8000_0000)
            return 64'h4000_0000_0000_0000;
        return m * m;
    endfunction

    function automatic logic [63:0] curve_flatness(logic [63:0] x[4], logic [63:0] y[4]);
        logic [63:0] ux, vx, uy, vy;
        ux = axis_dev(x[1], x[0], x[3]);
        vx = axis_dev(x[2], x[3], x[0]);
        uy = axis_dev(y[1], y[0], y[3]);
        vy = axis_dev(y[2], y[3], y[0]);
        return ((ux < vx) ? vx : ux) + ((uy < vy) ? vy : uy);
    endfunction

    function automatic logic [63:0] bernstein(logic [63:0] p[4], logic [63:0] a,
                                              logic [63:0] j, logic [63:0] den);
        logic [63:0] s;
        s = a*a*a*p[0] + 3*a*a*j*p[1] + 3*a*j*j*p[2] + j*j*j*p[3];
        return (s + den / 2) / den;
    endfunction

    function automatic void split_half(logic [63:0] p[4], output logic [63:0] l[4],
                                       output logic [63:0] r[4]);
        logic [63:0] a, b, c, ab, bc, m;
        a  = (p[0] + p[1]) >> 1;
        b  = (p[1] + p[2]) >> 1;
        c  = (p[2] + p[3]) >> 1;
        ab = (a + b) >> 1;
        bc = (b + c) >> 1;
        m  = (ab + bc) >> 1;
        l = '{p[0], a, ab, m};
        r = '{m, bc, c, p[3]};
    endfunction

    function automatic void predict_points(cbf_seg_t s);
        logic [63:0] cx[4], cy[4], lx[4], ly[4], rx[4], ry[4];
        logic [63:0] sx[MAX_DEPTH][4], sy[MAX_DEPTH][4];
        int          sd[MAX_DEPTH];
        int          lvl, d;
        logic [63:0] n, den;
        cx = '{to_ofs(s.start_x), to_ofs(s.ctrl1_x), to_ofs(s.ctrl2_x), to_ofs(s.end_x)};
        cy = '{to_ofs(s.start_y), to_ofs(s.ctrl1_y), to_ofs(s.ctrl2_y), to_ofs(s.end_y)};
        if (s.first_segment)
            add_point(cx[0], cy[0]);
        if (tol_reg != 0)
        begin
            lvl = 0;
            d   = 0;
            forever
            begin
                if (d >= MAX_DEPTH || curve_flatness(cx, cy) <= tol_reg)
                begin
                    add_point(cx[3], cy[3]);
                    if (lvl == 0)
                        break;
                    lvl--;
                    cx = sx[lvl];
                    cy = sy[lvl];
                    d  = sd[lvl];
                end
                else
                begin
                    split_half(cx, lx, rx);
                    split_half(cy, ly, ry);
                    sx[lvl] = rx;
                    sy[lvl] = ry;
                    sd[lvl] = d + 1;
                    lvl++;
                    cx = lx;
                    cy = ly;
                    d++;
                end
            end
        end
        else
        begin
            n = (cnt_reg == 0) ? 1 : (cnt_reg > MAX_SAMPLES) ? MAX_SAMPLES : cnt_reg;
            den = n * n * n;
            for (logic [63:0] j = 1; j <= n; j++)
                add_point(bernstein(cx, n - j, j, den), bernstein(cy, n - j, j, den));
        end
        pending_pts[$].last_of_segment = 1'b1;
        pending_pts[$].end_of_path     = s.last_segment;
    endfunction

    // ---------------- checker ----------------

    always @(negedge clk)
    begin
        cbf_pt_t e;
        if (rst_n && pt_valid && pt_ready)
        begin
            if (pending_pts.size() == 0)
            begin
                $error("unexpected point x=%0d y=%0d", pt.point_x, pt.point_y);
                err_count++;
            end
            else
            begin
                e = pending_pts.pop_front();
                if (pt.point_x !== e.point_x)
                begin
                    $error("point_x expected %0d actual %0d", e.point_x, pt.point_x);
                    err_count++;
                end
                if (pt.point_y !== e.point_y)
                begin
                    $error("point_y expected %0d actual %0d", e.point_y, pt.point_y);
                    err_count++;
                end
                if (pt.last_of_segment !== e.last_of_segment)
                begin
                    $error("last_of_segment expected %0b actual %0b",
                           e.last_of_segment, pt.last_of_segment);
                    err_count++;
                end
                if (pt.end_of_path !== e.end_of_path)
                begin
                    $error("end_of_path expected %0b actual %0b",
                           e.end_of_path, pt.end_of_path);
                    err_count++;
                end
            end
        end
    end

    // receiver side
    initial
    begin
        pt_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                pt_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                hold_req = 1'b0;
                pt_ready <= 1'b1;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                pt_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                pt_ready <= 1'b1;
            end
            else
                pt_ready <= 1'b1;
        end
    end

    // ---------------- sender and register access ----------------

    task automatic send_segment(cbf_seg_t s);
        bit rdy;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            seg_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        seg_valid <= 1'b1;
        seg       <= s;
        do
        begin
            @(negedge clk);
            rdy = seg_ready;
            @(posedge clk);
        end
        while (!rdy);
        predict_points(s);
    endtask

    task automatic wait_idle();
        seg_valid <= 1'b0;
        while (pending_pts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic sel, logic [63:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_TOL)
            tol_reg = value & TOL_MAX;
        else
            cnt_reg = value[5:0];
    endtask

    function automatic cbf_seg_t make_seg(logic [23:0] v[8], bit f, bit l);
        cbf_seg_t s;
        s = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], f, l};
        return s;
    endfunction

    function automatic cbf_seg_t random_seg();
        logic [23:0] v[8];
        logic [23:0] bx, by;
        int          k;
        k  = $urandom_range(0, 20);
        bx = 24'($urandom);
        by = 24'($urandom);
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(0, 3))
                0: v[i] = 24'($urandom);
                default: v[i] = 24'(((i % 2) ? by : bx) + ($urandom & ((24'h1 << k) - 1))
                                    - (24'h1 << (k > 0 ? k - 1 : 0)));
            endcase
        end
        return make_seg(v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // ---------------- tests ----------------

    task automatic test_fixed_extremes();
        logic [23:0] lo[8], hi[8], mix[8];
        for (int i = 0; i < 8; i++)
        begin
            lo[i]  = 24'h80_0000;
            hi[i]  = 24'h7F_FFFF;
            mix[i] = (i % 3 == 0) ? 24'h80_0000 : 24'h7F_FFFF;
        end
        send_segment(make_seg(lo, 1'b1, 1'b0));
        send_segment(make_seg(hi, 1'b0, 1'b1));
        send_segment(make_seg(mix, 1'b1, 1'b1));
        send_segment(make_seg('{default: 24'h0}, 1'b0, 1'b0));
    endtask

    task automatic test_sample_counts();
        logic [5:0] counts[5] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd3};
        foreach (counts[i])
        begin
            write_reg(REG_CNT, 64'(counts[i]));
            send_segment(random_seg());
            send_segment(random_seg());
        end
    endtask

    task automatic test_adaptive_extremes();
        logic [23:0] hi[8], zig[8];
        logic [63:0] tols[4] = '{64'd1, TOL_MAX, 64'h100_0000, 64'h1_0000_0000};
        for (int i = 0; i < 8; i++)
        begin
            hi[i]  = 24'h7F_FFFF;
            zig[i] = (i == 2 || i == 5) ? 24'h7F_FFFF : 24'h80_0000;
        end
        foreach (tols[i])
        begin
            write_reg(REG_TOL, tols[i]);
            send_segment(make_seg(zig, 1'b1, 1'b1));
            send_segment(make_seg(hi, 1'b0, 1'b0));
            send_segment(random_seg());
        end
    endtask

    task automatic test_random_phases(int phases, int per_phase);
        logic [63:0] t;
        for (int p = 0; p < phases; p++)
        begin
            case ($urandom_range(0, 4))
                0: t = '0;
                1: t = 64'($urandom_range(1, 255));
                2: t = 64'h1 << $urandom_range(0, 47);
                3: t = {$urandom, $urandom} & TOL_MAX;
                default: t = TOL_MAX;
            endcase
            write_reg(REG_TOL, t);
            write_reg(REG_CNT, 64'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                                : $urandom_range(1, 6)));
            for (int i = 0; i < per_phase; i++)
                send_segment(random_seg());
        end
    endtask

    task automatic test_output_hold_off();
        write_reg(REG_TOL, 64'h1_0000);
        write_reg(REG_CNT, 64'd4);
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_segment(random_seg());
    endtask

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        seg_valid = 1'b0;
        seg       = '0;
        tol_reg   = '0;
        cnt_reg   = 6'(CNT_RESET);
        err_count = 0;
        idle_en   = 1'b1;
        hold_req  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fixed_extremes();
        test_sample_counts();
        test_adaptive_extremes();
        test_random_phases(6, 40);
        test_output_hold_off();
        idle_en = 1'b0;
        test_random_phases(1, 35);

        wait_idle();
        repeat (100) @(posedge clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

[sim.f]
+incdir+src
src/cbf_pkg.sv
src/cbf_div.sv
src/cubic_bezier_flattener.sv
test/tb_top.sv
